>>> rtl/blake2s_hash_engine_macros.svh
// assertion helpers
`ifndef BLAKE2S_HASH_ENGINE_MACROS_SVH
`define BLAKE2S_HASH_ENGINE_MACROS_SVH
`define B2S_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("%m: lbl");
`define B2S_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("%m: lbl");
`endif

>>> rtl/b2s_pkg.sv
`default_nettype none
package b2s_pkg;
  localparam int ROUNDS = 10;
  localparam int RND_W = 4;

  localparam logic [0:0] REG_DLEN = 1'b0;
  localparam logic [0:0] REG_KLEN = 1'b1;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic load_iv;
    logic store_word;
    logic start;
    logic step;
    logic finish;
    logic final_blk;
    logic [5:0] param_dl;
    logic [5:0] param_kl;
  } b2s_cmd_t;

  typedef enum logic [4:0] {
    ST_IN   = 5'b00001,
    ST_INIT = 5'b00010,
    ST_RUN  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_OUT  = 5'b10000
  } b2s_state_t;

  function automatic word_t iv_word(input logic [2:0] i);
    case (i)
      3'd0: iv_word = 32'h6A09E667;
      3'd1: iv_word = 32'hBB67AE85;
      3'd2: iv_word = 32'h3C6EF372;
      3'd3: iv_word = 32'hA54FF53A;
      3'd4: iv_word = 32'h510E527F;
      3'd5: iv_word = 32'h9B05688C;
      3'd6: iv_word = 32'h1F83D9AB;
      default: iv_word = 32'h5BE0CD19;
    endcase
  endfunction

  function automatic logic [63:0] sigma_row(input logic [RND_W-1:0] r);
    case (r)
      4'd0: sigma_row = 64'hFEDCBA9876543210;
      4'd1: sigma_row = 64'h357B20C16DF984AE;
      4'd2: sigma_row = 64'h491763EADF250C8B;
      4'd3: sigma_row = 64'h8F04A562EBCD1397;
      4'd4: sigma_row = 64'hD386CB1EFA427509;
      4'd5: sigma_row = 64'h91EF57D438B0A6C2;
      4'd6: sigma_row = 64'hB8293670A4DEF15C;
      4'd7: sigma_row = 64'hA2684F05931CE7BD;
      4'd8: sigma_row = 64'h5A417D2C803B9EF6;
      default: sigma_row = 64'h0DC3E9BF5167482A;
    endcase
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

>>> rtl/b2s_datapath.sv
`default_nettype none
module b2s_datapath
  import b2s_pkg::*;
(
  input  wire logic clk,
  input  wire b2s_cmd_t cmd,
  input  wire word_t msg_word,
  input  wire logic [3:0] wpos,
  input  wire logic [6:0] block_bytes,
  input  wire logic [RND_W-1:0] rnd,
  input  wire logic half,
  input  wire logic [2:0] out_idx,
  output word_t chain_out
);
  word_t h [8];
  word_t m [16];
  word_t v [16];
  logic [63:0] byte_total;
  logic [6:0] nb;
  logic [63:0] t_next;
  logic [63:0] srow;
  word_t ga [4], gb [4], gc [4], gd [4];
  word_t na [4], nbv [4], nc [4], nd [4];
  logic [3:0] ia [4], ib [4], ic [4], id [4];
  word_t x [4], y [4];
  logic [3:0] sx, sy;

  assign nb = (block_bytes > 7'd64) ? 7'd64 : block_bytes;
  assign t_next = byte_total + {57'd0, nb};
  assign srow = sigma_row(rnd);
  assign chain_out = h[out_idx];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ia[j] = 4'(j);
      ib[j] = half ? 4'(4 + ((j + 1) % 4)) : 4'(4 + j);
      ic[j] = half ? 4'(8 + ((j + 2) % 4)) : 4'(8 + j);
      id[j] = half ? 4'(12 + ((j + 3) % 4)) : 4'(12 + j);
      sx = srow[(half ? 8 : 0) * 4 + j * 8 +: 4];
      sy = srow[(half ? 8 : 0) * 4 + j * 8 + 4 +: 4];
      x[j] = m[sx];
      y[j] = m[sy];
      ga[j] = v[ia[j]];
      gb[j] = v[ib[j]];
      gc[j] = v[ic[j]];
      gd[j] = v[id[j]];
      na[j] = ga[j] + gb[j] + x[j];
      nd[j] = rotr(gd[j] ^ na[j], 16);
      nc[j] = gc[j] + nd[j];
      nbv[j] = rotr(gb[j] ^ nc[j], 12);
      na[j] = na[j] + nbv[j] + y[j];
      nd[j] = rotr(nd[j] ^ na[j], 8);
      nc[j] = nc[j] + nd[j];
      nbv[j] = rotr(nbv[j] ^ nc[j], 7);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_iv) begin
      for (int i = 1; i < 8; i++) h[i] <= iv_word(3'(i));
      h[0] <= iv_word(3'd0) ^ {8'd1, 8'd1, 2'd0, cmd.param_kl, 2'd0, cmd.param_dl};
    end
    if (cmd.load_iv) byte_total <= '0;
    else if (cmd.store_word && wpos == 4'd15) byte_total <= t_next;
    if (cmd.store_word) m[wpos] <= msg_word;
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) v[i] <= h[i];
      for (int i = 0; i < 4; i++) v[i+8] <= iv_word(3'(i));
      v[12] <= iv_word(3'd4) ^ byte_total[31:0];
      v[13] <= iv_word(3'd5) ^ byte_total[63:32];
      v[14] <= iv_word(3'd6) ^ {32{cmd.final_blk}};
      v[15] <= iv_word(3'd7);
    end
    if (cmd.step) begin
      for (int j = 0; j < 4; j++) begin
        v[ia[j]] <= na[j];
        v[ib[j]] <= nbv[j];
        v[ic[j]] <= nc[j];
        v[id[j]] <= nd[j];
      end
    end
    if (cmd.finish) begin
      for (int i = 0; i < 8; i++) h[i] <= h[i] ^ v[i] ^ v[i+8];
    end
  end
endmodule
`default_nettype wire

>>> rtl/b2s_ctrl.sv
`default_nettype none
module b2s_ctrl
  import b2s_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic req_ready,
  input  wire logic message_end,
  input  wire logic [5:0] dl_cfg,
  input  wire logic [5:0] kl_cfg,
  input  wire logic out_ready,
  output logic out_valid,
  output logic out_last,
  output logic [31:0] out_mask,
  output b2s_cmd_t cmd,
  output logic [3:0] wpos,
  output logic [RND_W-1:0] rnd,
  output logic half,
  output logic [2:0] out_idx
);
`include "blake2s_hash_engine_macros.svh"
  b2s_state_t state, state_next;
  logic fresh, final_blk;
  logic [5:0] dl, kl;
  logic [2:0] last_idx;
  logic acc;
  logic [5:0] rem;

  assign dl = (dl_cfg == 6'd0) ? 6'd1 : (dl_cfg > 6'd32) ? 6'd32 : dl_cfg;
  assign kl = (kl_cfg > 6'd32) ? 6'd32 : kl_cfg;
  assign last_idx = 3'((dl - 6'd1) >> 2);
  assign rem = dl - {1'b0, out_idx, 2'b00};
  assign req_ready = (state == ST_IN);
  assign acc = req_valid && req_ready;
  assign out_valid = (state == ST_OUT);
  assign out_last = (out_idx == last_idx);
  assign out_mask = (rem >= 6'd4) ? 32'hFFFFFFFF :
                    (rem == 6'd3) ? 32'h00FFFFFF :
                    (rem == 6'd2) ? 32'h0000FFFF : 32'h000000FF;

  always_comb begin
    cmd = '0;
    cmd.param_dl = dl;
    cmd.param_kl = kl;
    cmd.final_blk = final_blk;
    cmd.load_iv = acc && fresh;
    cmd.store_word = acc;
    cmd.start = (state == ST_INIT);
    cmd.step = (state == ST_RUN);
    cmd.finish = (state == ST_FIN);
    state_next = state;
    case (state)
      ST_IN: if (acc && wpos == 4'd15) state_next = ST_INIT;
      ST_INIT: state_next = ST_RUN;
      ST_RUN: if (half && rnd == RND_W'(ROUNDS - 1)) state_next = ST_FIN;
      ST_FIN: state_next = final_blk ? ST_OUT : ST_IN;
      ST_OUT: if (out_ready && out_last) state_next = ST_IN;
      default: state_next = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IN;
      fresh <= 1'b1;
      wpos <= '0;
      rnd <= '0;
      half <= 1'b0;
      out_idx <= '0;
      final_blk <= 1'b0;
    end else begin
      state <= state_next;
      if (acc) begin
        fresh <= 1'b0;
        wpos <= wpos + 4'd1;
        if (wpos == 4'd15) final_blk <= message_end;
      end
      if (state == ST_INIT) begin
        rnd <= '0;
        half <= 1'b0;
      end
      if (state == ST_RUN) begin
        half <= ~half;
        if (half) rnd <= rnd + RND_W'(1);
      end
      if (state == ST_OUT && out_ready) begin
        if (out_last) begin
          out_idx <= '0;
          fresh <= 1'b1;
        end else begin
          out_idx <= out_idx + 3'd1;
        end
      end
    end
  end

  `B2S_ASSERT_IMP(a_ready_only_in, req_ready, state == ST_IN)
  `B2S_ASSERT_IMP(a_out_idx_range, out_valid, out_idx <= last_idx)
  `B2S_ASSERT_NEXT(a_block_start, acc && wpos == 4'd15, state == ST_INIT)
  `B2S_ASSERT_IMP(a_run_round, state == ST_RUN, rnd < RND_W'(ROUNDS))
endmodule
`default_nettype wire

>>> rtl/blake2s_hash_engine.sv
// Each block takes 16 accepted words, then compression in ST_INIT, ST_RUN (ROUNDS rounds)
// and ST_FIN; no words are accepted until it and any digest output are done. Four G units
// each do a full G per cycle, so each round is a column step and then a diagonal step.
// Digest words follow the final block, one per cycle while ready is high.
// Reset (rst, synchronous) clears control and config (digest 32, key 0).
`default_nettype none
module blake2s_hash_engine
  import b2s_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [5:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [31:0] msg_word,
  input  wire logic [6:0] block_bytes,
  input  wire logic message_end,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [31:0] digest_word,
  output logic last_word
);
  logic [5:0] dig_len, key_length;
  b2s_cmd_t cmd;
  logic [3:0] wpos;
  logic [RND_W-1:0] rnd;
  logic half;
  logic [2:0] out_idx;
  logic [31:0] mask;
  word_t chain_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      dig_len <= 6'd32;
      key_length <= 6'd0;
    end else if (cfg_we) begin
      if (cfg_index == REG_DLEN) dig_len <= cfg_data;
      else key_length <= cfg_data;
    end
  end

  b2s_ctrl u_ctrl (
    .clk, .rst, .req_valid(in_valid), .req_ready(in_ready), .message_end,
    .dl_cfg(dig_len), .kl_cfg(key_length), .out_ready, .out_valid,
    .out_last(last_word), .out_mask(mask), .cmd, .wpos, .rnd, .half, .out_idx
  );

  b2s_datapath u_dp (
    .clk, .cmd, .msg_word, .wpos, .block_bytes, .rnd, .half, .out_idx, .chain_out
  );

  assign digest_word = chain_out & mask;
endmodule
`default_nettype wire

>>> tb/blake2s_hash_checker.sv
`default_nettype none
module blake2s_hash_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [5:0]  cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [31:0] msg_word,
  input  wire logic [6:0]  block_bytes,
  input  wire logic        message_end,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] digest_word,
  input  wire logic        last_word,
  output int               fail_count,
  output int               digests_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [0:0] REG_DL = 1'd0;
  localparam logic [0:0] REG_KL = 1'd1;
  localparam int NROUNDS = 10;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_t;

  logic [31:0] h[8];
  logic [31:0] mblk[16];
  logic [31:0] v[16];
  logic [3:0]  wpos;
  logic [63:0] tcount;
  logic        fresh;
  logic [5:0]  dl_reg, kl_reg;
  digest_t     digest_q[$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ivw(input int i);
    logic [31:0] t[8];
    t = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
          32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
    return t[i];
  endfunction

  function automatic int sig(input int r, input int k);
    int t[10][16];
    t = '{'{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15},
          '{14,10,4,8,9,15,13,6,1,12,0,2,11,7,5,3},
          '{11,8,12,0,5,2,15,13,10,14,3,6,7,1,9,4},
          '{7,9,3,1,13,12,11,14,2,6,5,10,4,0,15,8},
          '{9,0,5,7,2,4,10,15,14,1,11,12,6,8,3,13},
          '{2,12,6,10,0,11,8,3,4,13,7,5,15,14,1,9},
          '{12,5,1,15,14,13,4,10,0,7,6,3,9,2,8,11},
          '{13,11,7,14,12,1,3,9,5,0,15,4,8,6,2,10},
          '{6,15,14,9,11,3,0,8,12,2,13,7,1,4,10,5},
          '{10,2,8,4,7,6,1,5,15,11,9,14,3,12,13,0}};
    return t[r][k];
  endfunction

  task automatic gmix(input int a, input int b, input int c, input int d,
                      input logic [31:0] x, input logic [31:0] y);
    v[a] = v[a] + v[b] + x; v[d] = ror(v[d] ^ v[a], 16);
    v[c] = v[c] + v[d];     v[b] = ror(v[b] ^ v[c], 12);
    v[a] = v[a] + v[b] + y; v[d] = ror(v[d] ^ v[a], 8);
    v[c] = v[c] + v[d];     v[b] = ror(v[b] ^ v[c], 7);
  endtask

  function automatic logic [5:0] eff_dl();
    if (dl_reg == 0) return 6'd1;
    if (dl_reg > 32) return 6'd32;
    return dl_reg;
  endfunction

  task automatic compress_block(input logic fin);
    for (int i = 0; i < 8; i++) begin
      v[i] = h[i];
      v[i+8] = ivw(i);
    end
    v[12] ^= tcount[31:0];
    v[13] ^= tcount[63:32];
    if (fin) v[14] = ~v[14];
    for (int r = 0; r < NROUNDS; r++) begin
      gmix(0, 4, 8, 12, mblk[sig(r,0)], mblk[sig(r,1)]);
      gmix(1, 5, 9, 13, mblk[sig(r,2)], mblk[sig(r,3)]);
      gmix(2, 6, 10, 14, mblk[sig(r,4)], mblk[sig(r,5)]);
      gmix(3, 7, 11, 15, mblk[sig(r,6)], mblk[sig(r,7)]);
      gmix(0, 5, 10, 15, mblk[sig(r,8)], mblk[sig(r,9)]);
      gmix(1, 6, 11, 12, mblk[sig(r,10)], mblk[sig(r,11)]);
      gmix(2, 7, 8, 13, mblk[sig(r,12)], mblk[sig(r,13)]);
      gmix(3, 4, 9, 14, mblk[sig(r,14)], mblk[sig(r,15)]);
    end
    for (int i = 0; i < 8; i++) h[i] ^= v[i] ^ v[i+8];
  endtask

  task automatic absorb_word(input logic [31:0] w, input logic [6:0] nb,
                             input logic fin);
    logic [5:0] kl, dl;
    logic [6:0] n;
    int nw, rem;
    digest_t d;
    if (fresh) begin
      kl = (kl_reg > 32) ? 6'd32 : kl_reg;
      for (int i = 0; i < 8; i++) h[i] = ivw(i);
      h[0] ^= {8'd1, 8'd1, 2'b0, kl, 2'b0, eff_dl()};
      tcount = '0;
      wpos = '0;
      fresh = 1'b0;
    end
    mblk[wpos] = w;
    if (wpos != 4'd15) begin
      wpos++;
      return;
    end
    wpos = '0;
    n = (nb > 64) ? 7'd64 : nb;
    tcount += n;
    compress_block(fin);
    if (!fin) return;
    dl = eff_dl();
    nw = (dl + 3) / 4;
    for (int i = 0; i < nw; i++) begin
      d.word = h[i];
      rem = dl - 4 * i;
      if (rem < 4) d.word &= (32'd1 << (8 * rem)) - 1;
      d.last = (i == nw - 1);
      digest_q.push_back(d);
    end
    fresh = 1'b1;
  endtask

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  assign digests_pending = digest_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    digest_t d;
    if (rst) begin
      dl_reg = 6'd32;
      kl_reg = 6'd0;
      wpos = '0;
      tcount = '0;
      fresh = 1'b1;
      digest_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          report($sformatf("unexpected digest word %h", digest_word));
        end else begin
          d = digest_q.pop_front();
          if (digest_word !== d.word)
            report($sformatf("digest_word %h, want %h", digest_word, d.word));
          if (last_word !== d.last)
            report($sformatf("last_word %b, want %b", last_word, d.last));
        end
      end
      if (in_valid && in_ready) absorb_word(msg_word, block_bytes, message_end);
      if (cfg_we) begin
        if (cfg_index == REG_DL) dl_reg = cfg_data;
        else if (cfg_index == REG_KL) kl_reg = cfg_data;
      end
    end
  end
endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [0:0] REG_DL = 1'd0;
  localparam logic [0:0] REG_KL = 1'd1;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] msg_word = '0;
  logic [6:0] block_bytes = '0;
  logic message_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] digest_word;
  logic last_word;
  int fail_count, digests_pending;
  longint cycles = 0;
  bit calm = 1'b0;
  int words_sent = 0;

  always #1 clk = ~clk;

  blake2s_hash_engine i_dut (.*);
  blake2s_hash_checker i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** blake2s_hash_engine: FAILED **");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= calm || ($urandom_range(99) >= 24);

  task automatic send_word(input logic [31:0] w, input logic [6:0] nb,
                           input logic fin);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    msg_word <= w;
    block_bytes <= nb;
    message_end <= fin;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // one block; mode 0 random words, 1 all zero, 2 all ones
  task automatic send_block(input logic [6:0] nb, input logic fin, input int mode);
    logic [31:0] w;
    for (int i = 0; i < 16; i++) begin
      w = (mode == 1) ? 32'h0 : (mode == 2) ? 32'hFFFFFFFF : $urandom;
      send_word(w, nb, (i == 15) ? fin : logic'($urandom_range(1)));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (digests_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [5:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_message(input int nblocks);
    for (int b = 0; b < nblocks; b++)
      send_block((b == nblocks - 1) ? 7'($urandom_range(64)) : 7'd64,
                 b == nblocks - 1, 0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed
    send_block(7'd0, 1'b1, 1);
    send_block(7'd127, 1'b1, 2);
    drain();
    write_reg(REG_DL, 6'd1);
    write_reg(REG_KL, 6'd32);
    send_block(7'd64, 1'b0, 0);
    send_block(7'd65, 1'b1, 0);
    drain();
    write_reg(REG_DL, 6'd0);
    write_reg(REG_KL, 6'd63);
    send_block(7'd3, 1'b1, 0);
    drain();
    write_reg(REG_DL, 6'd63);
    write_reg(REG_KL, 6'd0);
    send_block(7'd1, 1'b1, 0);
    drain();
    // random
    while (words_sent < 210) begin
      calm = (words_sent >= 100 && words_sent < 170);
      write_reg(REG_DL, 6'($urandom_range(63)));
      write_reg(REG_KL, 6'($urandom_range(63)));
      send_message($urandom_range(1, 3));
      if ($urandom_range(3) == 0) begin
        drain();
        write_reg(REG_DL, 6'($urandom_range(63)));
        send_message(1);
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("** blake2s_hash_engine: PASSED **");
    end else begin
      $display("** blake2s_hash_engine: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/b2s_pkg.sv
rtl/b2s_datapath.sv
rtl/b2s_ctrl.sv
rtl/blake2s_hash_engine.sv
tb/blake2s_hash_checker.sv
tb/tb_top.sv
